[hw/rtl/flow_table_with_aging_counts_assert.svh]
// Assertion macros for the flow table checker.
// Included by ftac_checker.sv; no other dependencies.
`ifndef FLOW_TABLE_WITH_AGING_COUNTS_ASSERT_SVH
`define FLOW_TABLE_WITH_AGING_COUNTS_ASSERT_SVH

// same-cycle implication
`define FTAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow table check failed");

// next-cycle implication
`define FTAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow table check failed");

`endif

[hw/rtl/ftac_pkg.sv]
// Shared constants, types and helpers of the flow table.
// No dependencies.
package ftac_pkg;

    localparam int FLOW_ENTRIES   = 1024;
    localparam int EGRESS_ENTRIES = 1024;
    localparam int NUM_PORTS      = 64;
    localparam int NUM_QUEUES     = 8;

    localparam int PQ_DEPTH = NUM_PORTS * NUM_QUEUES;
    localparam int PQ_W     = (PQ_DEPTH > 1) ? $clog2(PQ_DEPTH) : 1;
    localparam int IN_AW    = $clog2(FLOW_ENTRIES);
    localparam int EG_AW    = $clog2(EGRESS_ENTRIES);
    localparam int CNT_W    = $clog2(FLOW_ENTRIES + 1);
    localparam int QCNT_W   = $clog2(EGRESS_ENTRIES + 1);
    localparam int CLR_N    = (FLOW_ENTRIES > EGRESS_ENTRIES) ?
                              ((FLOW_ENTRIES > PQ_DEPTH) ? FLOW_ENTRIES : PQ_DEPTH) :
                              ((EGRESS_ENTRIES > PQ_DEPTH) ? EGRESS_ENTRIES : PQ_DEPTH);
    localparam int SC_W     = $clog2(CLR_N + 1);

    localparam int OUT_W   = 11;
    localparam int OUT_MAX = 2047;

    localparam logic [31:0] THR_RESET = 32'd50000;

    localparam logic [1:0] OP_INGRESS = 2'd0;
    localparam logic [1:0] OP_EGRESS  = 2'd1;
    localparam logic [1:0] OP_SWEEP   = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NOP   = 2'd0;
    localparam t_kind KIND_IN    = 2'd1;
    localparam t_kind KIND_EG    = 2'd2;
    localparam t_kind KIND_SWEEP = 2'd3;

    typedef struct packed {
        t_kind            kind;
        logic [31:0]      src_addr;
        logic [31:0]      dst_addr;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic [PQ_W-1:0]  pq;
        logic [47:0]      now_time;
    } t_cmd;

    typedef struct packed {
        logic             new_flow;
        logic             table_full;
        logic [OUT_W-1:0] dst_cnt;
        logic [OUT_W-1:0] src_cnt;
        logic [OUT_W-1:0] queue_cnt;
        logic [OUT_W-1:0] rm_in;
        logic [OUT_W-1:0] rm_eg;
    } t_res;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [47:0] last;
    } t_in_ent;

    typedef struct packed {
        logic            valid;
        logic [63:0]     addrs;
        logic [31:0]     ports;
        logic [PQ_W-1:0] pq;
        logic [47:0]     last;
    } t_eg_ent;

    typedef struct packed {
        logic [31:0]      key;
        logic [CNT_W-1:0] cnt;
    } t_cnt_ent;

    function automatic logic [OUT_W-1:0] sat_cnt(input logic [31:0] v);
        if (v > 32'(OUT_MAX)) begin
            return OUT_W'(OUT_MAX);
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

[hw/rtl/ftac_front.sv]
// Front end: accepts items, classifies them, holds them in a two-entry queue.
// Depends on ftac_pkg.
module ftac_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_operation,
    input  logic [31:0]          i_src_addr,
    input  logic [31:0]          i_dst_addr,
    input  logic [15:0]          i_src_port,
    input  logic [15:0]          i_dst_port,
    input  logic [5:0]           i_egress_port,
    input  logic [2:0]           i_queue_index,
    input  logic [47:0]          i_now_time,
    output logic                 o_cmd_valid,
    output ftac_pkg::t_cmd       o_cmd,
    input  logic                 i_cmd_ready
);

    ftac_pkg::t_cmd r_q [0:1];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    ftac_pkg::t_cmd cls;
    logic           in_rng;
    logic [31:0]    pq_full;
    logic           push_ok;
    logic           pop_ok;

    assign in_rng  = (32'(i_egress_port) < 32'(ftac_pkg::NUM_PORTS)) &&
                     (32'(i_queue_index) < 32'(ftac_pkg::NUM_QUEUES));
    assign pq_full = 32'(i_egress_port) * 32'(ftac_pkg::NUM_QUEUES) + 32'(i_queue_index);

    always_comb begin
        cls.src_addr = i_src_addr;
        cls.dst_addr = i_dst_addr;
        cls.src_port = i_src_port;
        cls.dst_port = i_dst_port;
        cls.pq       = pq_full[ftac_pkg::PQ_W-1:0];
        cls.now_time = i_now_time;
        unique case (i_operation)
            ftac_pkg::OP_INGRESS: cls.kind = ftac_pkg::KIND_IN;
            ftac_pkg::OP_EGRESS:  cls.kind = in_rng ? ftac_pkg::KIND_EG : ftac_pkg::KIND_NOP;
            ftac_pkg::OP_SWEEP:   cls.kind = ftac_pkg::KIND_SWEEP;
            default:              cls.kind = ftac_pkg::KIND_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push_ok && pop_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[hw/rtl/ftac_back.sv]
// Back end: table memories, scan sequencer, count updates and result register.
// Depends on ftac_pkg.
module ftac_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  ftac_pkg::t_cmd  i_cmd,
    output logic            o_cmd_ready,
    input  logic [31:0]     i_threshold,
    input  logic            i_pop,
    output logic            o_empty,
    output ftac_pkg::t_res  o_res
);

    localparam int IN_AW  = ftac_pkg::IN_AW;
    localparam int EG_AW  = ftac_pkg::EG_AW;
    localparam int PQ_W   = ftac_pkg::PQ_W;
    localparam int CNT_W  = ftac_pkg::CNT_W;
    localparam int QCNT_W = ftac_pkg::QCNT_W;
    localparam int SC_W   = ftac_pkg::SC_W;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CSCAN = 3'd3;
    localparam logic [2:0] S_PQA   = 3'd4;
    localparam logic [2:0] S_PQW   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [1:0] CM_READ  = 2'd0;
    localparam logic [1:0] CM_RAISE = 2'd1;
    localparam logic [1:0] CM_LOWER = 2'd2;

    localparam logic [SC_W-1:0] IN_LAST  = SC_W'(ftac_pkg::FLOW_ENTRIES - 1);
    localparam logic [SC_W-1:0] EG_LAST  = SC_W'(ftac_pkg::EGRESS_ENTRIES - 1);
    localparam logic [SC_W-1:0] CLR_LAST = SC_W'(ftac_pkg::CLR_N - 1);

    // memories
    ftac_pkg::t_in_ent  in_mem [0:ftac_pkg::FLOW_ENTRIES-1];
    ftac_pkg::t_eg_ent  eg_mem [0:ftac_pkg::EGRESS_ENTRIES-1];
    ftac_pkg::t_cnt_ent dc_mem [0:ftac_pkg::FLOW_ENTRIES-1];
    ftac_pkg::t_cnt_ent sc_mem [0:ftac_pkg::FLOW_ENTRIES-1];
    logic [QCNT_W-1:0]  pq_mem [0:ftac_pkg::PQ_DEPTH-1];

    ftac_pkg::t_in_ent  r_in_rd;
    ftac_pkg::t_eg_ent  r_eg_rd;
    ftac_pkg::t_cnt_ent r_dc_rd;
    ftac_pkg::t_cnt_ent r_sc_rd;
    logic [QCNT_W-1:0]  r_pq_rd;

    // sequencer state
    logic [2:0]        r_st;
    ftac_pkg::t_cmd    r_cmd;
    logic [SC_W-1:0]   r_ra;
    logic [SC_W-1:0]   r_ca;
    logic              r_cv;
    logic              r_tbl;
    logic              r_free_v;
    logic [SC_W-1:0]   r_free_idx;
    logic [1:0]        r_cm;
    logic              r_dm;
    logic [IN_AW-1:0]  r_dm_idx;
    logic [CNT_W-1:0]  r_dm_cnt;
    logic              r_df;
    logic [IN_AW-1:0]  r_df_idx;
    logic              r_sm;
    logic [IN_AW-1:0]  r_sm_idx;
    logic [CNT_W-1:0]  r_sm_cnt;
    logic              r_sf;
    logic [IN_AW-1:0]  r_sf_idx;
    logic [31:0]       r_dkey;
    logic [31:0]       r_skey;
    logic [SC_W-1:0]   r_resume;
    logic [PQ_W-1:0]   r_pq_addr;
    logic              r_new_flow;
    logic              r_full;
    logic [CNT_W-1:0]  r_dcnt_o;
    logic [CNT_W-1:0]  r_scnt_o;
    logic [QCNT_W-1:0] r_qcnt_o;
    logic [CNT_W-1:0]  r_rin;
    logic [QCNT_W-1:0] r_reg;
    logic              r_out_v;
    ftac_pkg::t_res    r_out;

    // write ports
    logic               in_we;
    logic [IN_AW-1:0]   in_wa;
    ftac_pkg::t_in_ent  in_wd;
    logic               eg_we;
    logic [EG_AW-1:0]   eg_wa;
    ftac_pkg::t_eg_ent  eg_wd;
    logic               dc_we;
    logic [IN_AW-1:0]   dc_wa;
    ftac_pkg::t_cnt_ent dc_wd;
    logic               sc_we;
    logic [IN_AW-1:0]   sc_wa;
    ftac_pkg::t_cnt_ent sc_wd;
    logic               pq_we;
    logic [PQ_W-1:0]    pq_wa;
    logic [QCNT_W-1:0]  pq_wd;

    // evaluation
    logic [63:0]       cmd_addrs;
    logic [31:0]       cmd_ports;
    logic              e_valid;
    logic              e_match;
    logic [47:0]       e_last;
    logic [47:0]       e_age;
    logic              e_idle;
    logic              lookup;
    logic [SC_W-1:0]   tbl_last;
    logic              at_end;
    logic              hit_now;
    logic              free_now;
    logic              rm_now;
    logic              c_end;
    logic              dm_now, df_now, sm_now, sf_now;
    logic              d_m, d_f, s_m, s_f;
    logic [IN_AW-1:0]  d_midx, d_fidx, s_midx, s_fidx;
    logic [CNT_W-1:0]  d_mcnt, s_mcnt;
    logic [CNT_W-1:0]  d_res, s_res;
    ftac_pkg::t_res    res;

    assign cmd_addrs = {r_cmd.src_addr, r_cmd.dst_addr};
    assign cmd_ports = {r_cmd.src_port, r_cmd.dst_port};
    assign e_valid   = r_tbl ? r_eg_rd.valid : r_in_rd.valid;
    assign e_match   = r_tbl ? (r_eg_rd.addrs == cmd_addrs && r_eg_rd.ports == cmd_ports &&
                                r_eg_rd.pq == r_cmd.pq)
                             : (r_in_rd.addrs == cmd_addrs && r_in_rd.ports == cmd_ports);
    assign e_last    = r_tbl ? r_eg_rd.last : r_in_rd.last;
    assign e_age     = r_cmd.now_time - e_last;
    assign e_idle    = e_age > {16'd0, i_threshold};
    assign lookup    = (r_cmd.kind != ftac_pkg::KIND_SWEEP);
    assign tbl_last  = r_tbl ? EG_LAST : IN_LAST;
    assign at_end    = (r_st == S_SCAN) && r_cv && (r_ca == tbl_last);
    assign hit_now   = (r_st == S_SCAN) && lookup && r_cv && e_valid && e_match;
    assign free_now  = (r_st == S_SCAN) && r_cv && !e_valid && !r_free_v;
    assign rm_now    = (r_st == S_SCAN) && !lookup && r_cv && e_valid && e_idle;

    assign c_end  = (r_st == S_CSCAN) && r_cv && (r_ca == IN_LAST);
    assign dm_now = r_cv && !r_dm && (r_dc_rd.cnt != '0) && (r_dc_rd.key == r_dkey);
    assign df_now = r_cv && !r_df && (r_dc_rd.cnt == '0);
    assign sm_now = r_cv && !r_sm && (r_sc_rd.cnt != '0) && (r_sc_rd.key == r_skey);
    assign sf_now = r_cv && !r_sf && (r_sc_rd.cnt == '0);
    assign d_m    = r_dm || dm_now;
    assign d_f    = r_df || df_now;
    assign s_m    = r_sm || sm_now;
    assign s_f    = r_sf || sf_now;
    assign d_midx = r_dm ? r_dm_idx : r_ca[IN_AW-1:0];
    assign d_fidx = r_df ? r_df_idx : r_ca[IN_AW-1:0];
    assign s_midx = r_sm ? r_sm_idx : r_ca[IN_AW-1:0];
    assign s_fidx = r_sf ? r_sf_idx : r_ca[IN_AW-1:0];
    assign d_mcnt = r_dm ? r_dm_cnt : r_dc_rd.cnt;
    assign s_mcnt = r_sm ? r_sm_cnt : r_sc_rd.cnt;

    always_comb begin
        if (d_m) begin
            d_res = (r_cm == CM_RAISE) ? d_mcnt + CNT_W'(1) : d_mcnt;
        end else begin
            d_res = ((r_cm == CM_RAISE) && d_f) ? CNT_W'(1) : '0;
        end
        if (s_m) begin
            s_res = (r_cm == CM_RAISE) ? s_mcnt + CNT_W'(1) : s_mcnt;
        end else begin
            s_res = ((r_cm == CM_RAISE) && s_f) ? CNT_W'(1) : '0;
        end
    end

    always_comb begin
        in_we = 1'b0;
        in_wa = r_ca[IN_AW-1:0];
        in_wd = '0;
        eg_we = 1'b0;
        eg_wa = r_ca[EG_AW-1:0];
        eg_wd = '0;
        dc_we = 1'b0;
        dc_wa = d_midx;
        dc_wd = '0;
        sc_we = 1'b0;
        sc_wa = s_midx;
        sc_wd = '0;
        pq_we = 1'b0;
        pq_wa = r_pq_addr;
        pq_wd = '0;
        if (r_st == S_CLR) begin
            in_we = (r_ra <= IN_LAST);
            in_wa = r_ra[IN_AW-1:0];
            eg_we = (r_ra <= EG_LAST);
            eg_wa = r_ra[EG_AW-1:0];
            dc_we = (r_ra <= IN_LAST);
            dc_wa = r_ra[IN_AW-1:0];
            sc_we = (r_ra <= IN_LAST);
            sc_wa = r_ra[IN_AW-1:0];
            pq_we = (32'(r_ra) < 32'(ftac_pkg::PQ_DEPTH));
            pq_wa = r_ra[PQ_W-1:0];
        end else if (r_st == S_SCAN) begin
            if (lookup) begin
                in_wd = '{valid: 1'b1, addrs: cmd_addrs, ports: cmd_ports,
                          last: r_cmd.now_time};
                eg_wd = '{valid: 1'b1, addrs: cmd_addrs, ports: cmd_ports,
                          pq: r_cmd.pq, last: r_cmd.now_time};
                if (hit_now) begin
                    in_we = !r_tbl;
                    eg_we = r_tbl;
                end else if (at_end && (r_free_v || free_now)) begin
                    in_we = !r_tbl;
                    eg_we = r_tbl;
                    in_wa = r_free_v ? r_free_idx[IN_AW-1:0] : r_ca[IN_AW-1:0];
                    eg_wa = r_free_v ? r_free_idx[EG_AW-1:0] : r_ca[EG_AW-1:0];
                end
            end else begin
                in_wd       = r_in_rd;
                in_wd.valid = 1'b0;
                eg_wd       = r_eg_rd;
                eg_wd.valid = 1'b0;
                in_we       = rm_now && !r_tbl;
                eg_we       = rm_now && r_tbl;
            end
        end else if (r_st == S_CSCAN) begin
            if (c_end && (r_cm == CM_RAISE)) begin
                dc_we = d_m || d_f;
                dc_wa = d_m ? d_midx : d_fidx;
                dc_wd = '{key: r_dkey, cnt: d_res};
                sc_we = s_m || s_f;
                sc_wa = s_m ? s_midx : s_fidx;
                sc_wd = '{key: r_skey, cnt: s_res};
            end else if (c_end && (r_cm == CM_LOWER)) begin
                dc_we = d_m;
                dc_wd = '{key: r_dkey, cnt: d_mcnt - CNT_W'(1)};
                sc_we = s_m;
                sc_wd = '{key: r_skey, cnt: s_mcnt - CNT_W'(1)};
            end
        end else if (r_st == S_PQW) begin
            if (lookup) begin
                pq_we = r_new_flow;
                pq_wd = r_pq_rd + QCNT_W'(1);
            end else begin
                pq_we = (r_pq_rd != '0);
                pq_wd = r_pq_rd - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_we) begin
            in_mem[in_wa] <= in_wd;
        end
        r_in_rd <= in_mem[r_ra[IN_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (eg_we) begin
            eg_mem[eg_wa] <= eg_wd;
        end
        r_eg_rd <= eg_mem[r_ra[EG_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (dc_we) begin
            dc_mem[dc_wa] <= dc_wd;
        end
        r_dc_rd <= dc_mem[r_ra[IN_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            sc_mem[sc_wa] <= sc_wd;
        end
        r_sc_rd <= sc_mem[r_ra[IN_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pq_we) begin
            pq_mem[pq_wa] <= pq_wd;
        end
        r_pq_rd <= pq_mem[r_pq_addr];
    end

    assign res.new_flow   = r_new_flow;
    assign res.table_full = r_full;
    assign res.dst_cnt    = ftac_pkg::sat_cnt(32'(r_dcnt_o));
    assign res.src_cnt    = ftac_pkg::sat_cnt(32'(r_scnt_o));
    assign res.queue_cnt  = ftac_pkg::sat_cnt(32'(r_qcnt_o));
    assign res.rm_in      = ftac_pkg::sat_cnt(32'(r_rin));
    assign res.rm_eg      = ftac_pkg::sat_cnt(32'(r_reg));

    assign o_cmd_ready = (r_st == S_IDLE);
    assign o_empty     = !r_out_v;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_ra    <= '0;
            r_cv    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
            unique case (r_st)
                S_CLR: begin
                    r_ra <= r_ra + SC_W'(1);
                    if (r_ra == CLR_LAST) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd      <= i_cmd;
                        r_ra       <= '0;
                        r_cv       <= 1'b0;
                        r_tbl      <= (i_cmd.kind == ftac_pkg::KIND_EG);
                        r_free_v   <= 1'b0;
                        r_new_flow <= 1'b0;
                        r_full     <= 1'b0;
                        r_dcnt_o   <= '0;
                        r_scnt_o   <= '0;
                        r_qcnt_o   <= '0;
                        r_rin      <= '0;
                        r_reg      <= '0;
                        r_st       <= (i_cmd.kind == ftac_pkg::KIND_NOP) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_ra <= tbl_last) begin
                        r_ra <= r_ra + SC_W'(1);
                        r_ca <= r_ra;
                        r_cv <= 1'b1;
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (free_now) begin
                        r_free_v   <= 1'b1;
                        r_free_idx <= r_ca;
                    end
                    if (lookup) begin
                        if (hit_now || at_end) begin
                            if (!hit_now) begin
                                r_new_flow <= r_free_v || free_now;
                                r_full     <= !(r_free_v || free_now);
                            end
                            r_ra <= '0;
                            r_cv <= 1'b0;
                            if (!r_tbl) begin
                                r_dkey <= r_cmd.dst_addr;
                                r_skey <= r_cmd.src_addr;
                                r_cm   <= (!hit_now && (r_free_v || free_now)) ?
                                          CM_RAISE : CM_READ;
                                r_dm   <= 1'b0;
                                r_df   <= 1'b0;
                                r_sm   <= 1'b0;
                                r_sf   <= 1'b0;
                                r_st   <= S_CSCAN;
                            end else begin
                                r_pq_addr <= r_cmd.pq;
                                r_st      <= S_PQA;
                            end
                        end
                    end else if (rm_now) begin
                        r_resume <= r_ca + SC_W'(1);
                        r_cv     <= 1'b0;
                        if (!r_tbl) begin
                            r_rin  <= r_rin + CNT_W'(1);
                            r_dkey <= r_in_rd.addrs[31:0];
                            r_skey <= r_in_rd.addrs[63:32];
                            r_cm   <= CM_LOWER;
                            r_dm   <= 1'b0;
                            r_df   <= 1'b0;
                            r_sm   <= 1'b0;
                            r_sf   <= 1'b0;
                            r_ra   <= '0;
                            r_st   <= S_CSCAN;
                        end else begin
                            r_reg     <= r_reg + QCNT_W'(1);
                            r_pq_addr <= r_eg_rd.pq;
                            r_st      <= S_PQA;
                        end
                    end else if (at_end) begin
                        r_cv <= 1'b0;
                        if (!r_tbl) begin
                            r_tbl <= 1'b1;
                            r_ra  <= '0;
                        end else begin
                            r_st <= S_DONE;
                        end
                    end
                end
                S_CSCAN: begin
                    if (r_ra <= IN_LAST) begin
                        r_ra <= r_ra + SC_W'(1);
                        r_ca <= r_ra;
                        r_cv <= 1'b1;
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (dm_now) begin
                        r_dm     <= 1'b1;
                        r_dm_idx <= r_ca[IN_AW-1:0];
                        r_dm_cnt <= r_dc_rd.cnt;
                    end
                    if (df_now) begin
                        r_df     <= 1'b1;
                        r_df_idx <= r_ca[IN_AW-1:0];
                    end
                    if (sm_now) begin
                        r_sm     <= 1'b1;
                        r_sm_idx <= r_ca[IN_AW-1:0];
                        r_sm_cnt <= r_sc_rd.cnt;
                    end
                    if (sf_now) begin
                        r_sf     <= 1'b1;
                        r_sf_idx <= r_ca[IN_AW-1:0];
                    end
                    if (c_end) begin
                        r_cv <= 1'b0;
                        if (r_cm == CM_LOWER) begin
                            r_st <= S_SCAN;
                            if (r_resume > IN_LAST) begin
                                r_tbl <= 1'b1;
                                r_ra  <= '0;
                            end else begin
                                r_ra <= r_resume;
                            end
                        end else begin
                            r_dcnt_o <= d_res;
                            r_scnt_o <= s_res;
                            r_st     <= S_DONE;
                        end
                    end
                end
                S_PQA: begin
                    r_st <= S_PQW;
                end
                S_PQW: begin
                    if (lookup) begin
                        r_qcnt_o <= r_new_flow ? r_pq_rd + QCNT_W'(1) : r_pq_rd;
                        r_st     <= S_DONE;
                    end else if (r_resume > EG_LAST) begin
                        r_st <= S_DONE;
                    end else begin
                        r_ra <= r_resume;
                        r_cv <= 1'b0;
                        r_st <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (!r_out_v || i_pop) begin
                        r_out_v <= 1'b1;
                        r_out   <= res;
                        r_st    <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/flow_table_with_aging_counts.sv]
// Flow table with idle aging. An ingress item scans the ingress table, then the count tables;
// an egress item scans the egress table, then its queue count; a sweep scans both tables,
// with a count pass per ingress and a queue update per egress entry removed; unused codes scan nothing.
// One item in the back end at a time, next one taken the cycle after its result is registered;
// a waiting result stalls the back end. A two-entry queue takes items ahead of it.
// Reset (synchronous): 1024-cycle clearing pass before the first item; threshold 50000.
module flow_table_with_aging_counts (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [5:0]  i_egress_port,
    input  logic [2:0]  i_queue_index,
    input  logic [47:0] i_now_time,
    output logic        empty,
    input  logic        pop,
    output logic        o_new_flow,
    output logic        o_table_full,
    output logic [10:0] o_dst_flow_count,
    output logic [10:0] o_src_flow_count,
    output logic [10:0] o_queue_flow_count,
    output logic [10:0] o_removed_ingress,
    output logic [10:0] o_removed_egress,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic           threshold_we;
    logic [31:0]    r_threshold;
    logic           cmd_valid;
    logic           cmd_ready;
    ftac_pkg::t_cmd cmd;
    ftac_pkg::t_res res;

    assign o_cfg_ready  = 1'b1;
    assign threshold_we = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ftac_pkg::THR_RESET;
        end else if (threshold_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    ftac_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_operation   (i_operation),
        .i_src_addr    (i_src_addr),
        .i_dst_addr    (i_dst_addr),
        .i_src_port    (i_src_port),
        .i_dst_port    (i_dst_port),
        .i_egress_port (i_egress_port),
        .i_queue_index (i_queue_index),
        .i_now_time    (i_now_time),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_ready   (cmd_ready)
    );

    ftac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .i_threshold (r_threshold),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_new_flow         = res.new_flow;
    assign o_table_full       = res.table_full;
    assign o_dst_flow_count   = res.dst_cnt;
    assign o_src_flow_count   = res.src_cnt;
    assign o_queue_flow_count = res.queue_cnt;
    assign o_removed_ingress  = res.rm_in;
    assign o_removed_egress   = res.rm_eg;

endmodule

[hw/rtl/ftac_checker.sv]
// Port-level checks of the flow table, bound to the top level.
// Depends on flow_table_with_aging_counts_assert.svh.
`include "flow_table_with_aging_counts_assert.svh"

module ftac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_new_flow,
    input logic        o_table_full,
    input logic [10:0] o_dst_flow_count,
    input logic [10:0] o_src_flow_count,
    input logic [10:0] o_queue_flow_count,
    input logic [10:0] o_removed_ingress,
    input logic [10:0] o_removed_egress
);

    // a result can't be both an insert and a dropped insert
    `FTAC_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, !empty, !(o_new_flow && o_table_full))

    // an insert always leaves a nonzero count behind
    `FTAC_ASSERT_IMP(a_new_counts, i_clk, i_rst_n, !empty && o_new_flow, (o_dst_flow_count != 11'd0 && o_src_flow_count != 11'd0) || o_queue_flow_count != 11'd0)

    // sweep results carry only removal tallies
    `FTAC_ASSERT_IMP(a_sweep_only, i_clk, i_rst_n, !empty && (o_removed_ingress != 11'd0 || o_removed_egress != 11'd0), !o_new_flow && !o_table_full && o_dst_flow_count == 11'd0 && o_queue_flow_count == 11'd0)

    // a waiting result holds until the transfer
    `FTAC_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_dst_flow_count) && $stable(o_removed_ingress))

endmodule

bind flow_table_with_aging_counts ftac_checker u_ftac_checker (.*);

[test/flow_table_checker.sv]
// Checker for the flow table: watches the item, result and config transfers,
// predicts each result and compares it. Depends on ftac_pkg.
`timescale 1ns / 1ps
module flow_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [5:0]  i_egress_port,
    input  logic [2:0]  i_queue_index,
    input  logic [47:0] i_now_time,
    input  logic        empty,
    input  logic        pop,
    input  logic        o_new_flow,
    input  logic        o_table_full,
    input  logic [10:0] o_dst_flow_count,
    input  logic [10:0] o_src_flow_count,
    input  logic [10:0] o_queue_flow_count,
    input  logic [10:0] o_removed_ingress,
    input  logic [10:0] o_removed_egress,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    logic [31:0] idle_limit;

    logic        ing_valid [ftac_pkg::FLOW_ENTRIES];
    logic [63:0] ing_addrs [ftac_pkg::FLOW_ENTRIES];
    logic [31:0] ing_ports [ftac_pkg::FLOW_ENTRIES];
    logic [47:0] ing_seen  [ftac_pkg::FLOW_ENTRIES];

    logic                      egr_valid [ftac_pkg::EGRESS_ENTRIES];
    logic [63:0]               egr_addrs [ftac_pkg::EGRESS_ENTRIES];
    logic [31:0]               egr_ports [ftac_pkg::EGRESS_ENTRIES];
    logic [ftac_pkg::PQ_W-1:0] egr_pq    [ftac_pkg::EGRESS_ENTRIES];
    logic [47:0]               egr_seen  [ftac_pkg::EGRESS_ENTRIES];

    // index 0: per-destination counts, index 1: per-source counts
    logic [31:0] addr_key [2][ftac_pkg::FLOW_ENTRIES];
    int          addr_cnt [2][ftac_pkg::FLOW_ENTRIES];
    int          queue_cnt [ftac_pkg::PQ_DEPTH];

    ftac_pkg::t_res expected_results [$];

    function automatic int find_addr(input int side, input logic [31:0] addr);
        for (int i = 0; i < ftac_pkg::FLOW_ENTRIES; i++) begin
            if (addr_cnt[side][i] != 0 && addr_key[side][i] == addr) return i;
        end
        return -1;
    endfunction

    function automatic logic [10:0] sat11(input int v);
        return (v > ftac_pkg::OUT_MAX) ? 11'(ftac_pkg::OUT_MAX) : 11'(v);
    endfunction

    function automatic logic [10:0] addr_count(input int side, input logic [31:0] addr);
        int k;
        k = find_addr(side, addr);
        if (k < 0) return '0;
        return sat11(addr_cnt[side][k]);
    endfunction

    function automatic void bump_addr(input int side, input logic [31:0] addr, input int delta);
        int k;
        k = find_addr(side, addr);
        if (k >= 0) begin
            addr_cnt[side][k] += delta;
            return;
        end
        if (delta < 0) return;
        for (int i = 0; i < ftac_pkg::FLOW_ENTRIES; i++) begin
            if (addr_cnt[side][i] == 0) begin
                addr_key[side][i] = addr;
                addr_cnt[side][i] = 1;
                return;
            end
        end
    endfunction

    function automatic ftac_pkg::t_res predict_flow_update();
        ftac_pkg::t_res r;
        int hit, free_slot, rin, reg_n;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [31:0] pq_full;
        logic [ftac_pkg::PQ_W-1:0] pq;
        r = '0;
        hit = -1;
        free_slot = -1;
        addrs = {i_src_addr, i_dst_addr};
        ports = {i_src_port, i_dst_port};
        pq_full = 32'(int'(i_egress_port) * ftac_pkg::NUM_QUEUES + int'(i_queue_index));
        pq = pq_full[ftac_pkg::PQ_W-1:0];
        case (i_operation)
            ftac_pkg::OP_INGRESS: begin
                for (int i = 0; i < ftac_pkg::FLOW_ENTRIES; i++) begin
                    if (ing_valid[i]) begin
                        if (ing_addrs[i] == addrs && ing_ports[i] == ports) begin
                            hit = i;
                            break;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    ing_seen[hit] = i_now_time;
                end else if (free_slot >= 0) begin
                    ing_valid[free_slot] = 1'b1;
                    ing_addrs[free_slot] = addrs;
                    ing_ports[free_slot] = ports;
                    ing_seen[free_slot]  = i_now_time;
                    bump_addr(0, i_dst_addr, 1);
                    bump_addr(1, i_src_addr, 1);
                    r.new_flow = 1'b1;
                end else begin
                    r.table_full = 1'b1;
                end
                r.dst_cnt = addr_count(0, i_dst_addr);
                r.src_cnt = addr_count(1, i_src_addr);
            end
            ftac_pkg::OP_EGRESS: begin
                if (int'(i_egress_port) >= ftac_pkg::NUM_PORTS ||
                        int'(i_queue_index) >= ftac_pkg::NUM_QUEUES) return r;
                for (int i = 0; i < ftac_pkg::EGRESS_ENTRIES; i++) begin
                    if (egr_valid[i]) begin
                        if (egr_addrs[i] == addrs && egr_ports[i] == ports &&
                                egr_pq[i] == pq) begin
                            hit = i;
                            break;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    egr_seen[hit] = i_now_time;
                end else if (free_slot >= 0) begin
                    egr_valid[free_slot] = 1'b1;
                    egr_addrs[free_slot] = addrs;
                    egr_ports[free_slot] = ports;
                    egr_pq[free_slot]    = pq;
                    egr_seen[free_slot]  = i_now_time;
                    queue_cnt[pq]++;
                    r.new_flow = 1'b1;
                end else begin
                    r.table_full = 1'b1;
                end
                r.queue_cnt = sat11(queue_cnt[pq]);
            end
            ftac_pkg::OP_SWEEP: begin
                rin = 0;
                reg_n = 0;
                for (int i = 0; i < ftac_pkg::FLOW_ENTRIES; i++) begin
                    if (ing_valid[i] &&
                            48'(i_now_time - ing_seen[i]) > {16'd0, idle_limit}) begin
                        ing_valid[i] = 1'b0;
                        bump_addr(0, ing_addrs[i][31:0], -1);
                        bump_addr(1, ing_addrs[i][63:32], -1);
                        rin++;
                    end
                end
                for (int i = 0; i < ftac_pkg::EGRESS_ENTRIES; i++) begin
                    if (egr_valid[i] &&
                            48'(i_now_time - egr_seen[i]) > {16'd0, idle_limit}) begin
                        egr_valid[i] = 1'b0;
                        if (queue_cnt[egr_pq[i]] != 0) queue_cnt[egr_pq[i]]--;
                        reg_n++;
                    end
                end
                r.rm_in = sat11(rin);
                r.rm_eg = sat11(reg_n);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [10:0] got,
                                   input logic [10:0] want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        ftac_pkg::t_res want;
        ftac_pkg::t_res pred;
        if (!i_rst_n) begin
            idle_limit = ftac_pkg::THR_RESET;
            for (int i = 0; i < ftac_pkg::FLOW_ENTRIES; i++) begin
                ing_valid[i] = 1'b0;
                addr_cnt[0][i] = 0;
                addr_cnt[1][i] = 0;
            end
            for (int i = 0; i < ftac_pkg::EGRESS_ENTRIES; i++) egr_valid[i] = 1'b0;
            for (int i = 0; i < ftac_pkg::PQ_DEPTH; i++) queue_cnt[i] = 0;
            expected_results.delete();
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("pending results", 11'd0, 11'd1);
                end else begin
                    want = expected_results.pop_front();
                    if (o_new_flow != want.new_flow)
                        report_mismatch("new_flow", 11'(o_new_flow), 11'(want.new_flow));
                    if (o_table_full != want.table_full)
                        report_mismatch("table_full", 11'(o_table_full), 11'(want.table_full));
                    if (o_dst_flow_count != want.dst_cnt)
                        report_mismatch("dst_flow_count", o_dst_flow_count, want.dst_cnt);
                    if (o_src_flow_count != want.src_cnt)
                        report_mismatch("src_flow_count", o_src_flow_count, want.src_cnt);
                    if (o_queue_flow_count != want.queue_cnt)
                        report_mismatch("queue_flow_count", o_queue_flow_count, want.queue_cnt);
                    if (o_removed_ingress != want.rm_in)
                        report_mismatch("removed_ingress", o_removed_ingress, want.rm_in);
                    if (o_removed_egress != want.rm_eg)
                        report_mismatch("removed_egress", o_removed_egress, want.rm_eg);
                end
            end
            if (push && !full) begin
                pred = predict_flow_update();
                expected_results.insert(expected_results.size(), pred);
            end
            if (i_cfg_valid && o_cfg_ready) idle_limit = i_cfg_data;
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule

[test/tb_flow_table_with_aging_counts.sv]
// Testbench top for flow_table_with_aging_counts: drives packets, sweeps and
// threshold writes with random stalls. Depends on ftac_pkg and flow_table_checker.
`timescale 1ns / 1ps
module tb_flow_table_with_aging_counts;

    localparam longint CYCLE_LIMIT = 64'd60_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_operation;
    logic [31:0] i_src_addr;
    logic [31:0] i_dst_addr;
    logic [15:0] i_src_port;
    logic [15:0] i_dst_port;
    logic [5:0]  i_egress_port;
    logic [2:0]  i_queue_index;
    logic [47:0] i_now_time;
    logic        empty;
    logic        pop;
    logic        o_new_flow;
    logic        o_table_full;
    logic [10:0] o_dst_flow_count;
    logic [10:0] o_src_flow_count;
    logic [10:0] o_queue_flow_count;
    logic [10:0] o_removed_ingress;
    logic [10:0] o_removed_egress;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    int     fail_count;
    int     pending;
    longint cycle_count;
    bit     idling_on;
    int     pop_stall;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [5:0]  port;
        logic [2:0]  queue;
    } t_flow_pkt;

    t_flow_pkt   recent_flows [$];
    logic [31:0] addr_pool [8];
    logic [47:0] clock_now;

    flow_table_with_aging_counts dut (.*);

    flow_table_checker checker_u (.*, .o_fail_count(fail_count), .o_pending(pending));

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            pop <= 1'b0;
        end else if (idling_on && $urandom_range(0, 15) == 0) begin
            pop_stall <= $urandom_range(0, 11);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_pkt(input t_flow_pkt p, input logic [47:0] t);
        int gap;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push          <= 1'b1;
        i_operation   <= p.op;
        i_src_addr    <= p.sa;
        i_dst_addr    <= p.da;
        i_src_port    <= p.sp;
        i_dst_port    <= p.dp;
        i_egress_port <= p.port;
        i_queue_index <= p.queue;
        i_now_time    <= t;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        // push stays high; the next call either refreshes or drops it
        recent_flows.insert(recent_flows.size(), p);
        if (recent_flows.size() > 48) void'(recent_flows.pop_front());
    endtask

    task automatic drop_push();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    task automatic write_threshold(input logic [31:0] v);
        drop_push();
        while (pending != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_flow_pkt random_pkt();
        t_flow_pkt p;
        int sel;
        sel = $urandom_range(0, 99);
        if (recent_flows.size() > 0 && sel < 35) begin
            p = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
        end else begin
            p.sa    = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom;
            p.da    = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom;
            p.sp    = 16'($urandom);
            p.dp    = 16'($urandom);
            p.port  = 6'($urandom);
            p.queue = 3'($urandom);
        end
        sel = $urandom_range(0, 99);
        if (sel < 48) p.op = ftac_pkg::OP_INGRESS;
        else if (sel < 90) p.op = ftac_pkg::OP_EGRESS;
        else if (sel < 98) p.op = ftac_pkg::OP_SWEEP;
        else p.op = OP_UNUSED;
        return p;
    endfunction

    task automatic run_random(input int n, input bit big_steps);
        logic [47:0] step;
        for (int k = 0; k < n; k++) begin
            if (big_steps && $urandom_range(0, 9) == 0)
                step = {4'($urandom_range(0, 3)), 32'($urandom), 12'h0};
            else
                step = 48'($urandom_range(0, 9000));
            clock_now = clock_now + step;
            send_pkt(random_pkt(), clock_now);
        end
    endtask

    task automatic fill_table(input logic [1:0] op, input int n);
        t_flow_pkt p;
        for (int k = 0; k < n; k++) begin
            p.op    = op;
            p.sa    = $urandom;
            p.da    = addr_pool[$urandom_range(0, 7)];
            p.sp    = 16'($urandom);
            p.dp    = 16'($urandom);
            p.port  = 6'($urandom);
            p.queue = 3'($urandom);
            clock_now = clock_now + 48'd1;
            send_pkt(p, clock_now);
        end
    endtask

    initial begin
        t_flow_pkt p;
        push = 1'b0;
        pop = 1'b0;
        i_operation = ftac_pkg::OP_INGRESS;
        i_src_addr = '0;
        i_dst_addr = '0;
        i_src_port = '0;
        i_dst_port = '0;
        i_egress_port = '0;
        i_queue_index = '0;
        i_now_time = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        cycle_count = 0;
        pop_stall = 0;
        idling_on = 1'b1;
        i_rst_n = 1'b0;
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, every operation, unused code, timer wrap
        clock_now = 48'hFFFF_FFFF_F000;
        p = '{ftac_pkg::OP_INGRESS, 32'h0, 32'h0, 16'h0, 16'h0, 6'd0, 3'd0};
        send_pkt(p, clock_now);
        send_pkt(p, clock_now + 48'd10);
        p = '{ftac_pkg::OP_INGRESS, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF, 6'd63, 3'd7};
        send_pkt(p, clock_now + 48'd20);
        p = '{ftac_pkg::OP_INGRESS, 32'h0, 32'hFFFF_FFFF, 16'h1, 16'h2, 6'd0, 3'd0};
        send_pkt(p, clock_now + 48'd30);
        p = '{ftac_pkg::OP_EGRESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
              6'd63, 3'd7};
        send_pkt(p, clock_now + 48'd40);
        send_pkt(p, clock_now + 48'd50);
        p = '{ftac_pkg::OP_EGRESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
              6'd63, 3'd6};
        send_pkt(p, clock_now + 48'd60);
        p = '{ftac_pkg::OP_EGRESS, 32'h0, 32'h0, 16'h0, 16'h0, 6'd0, 3'd0};
        send_pkt(p, clock_now);
        p = '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 6'd63, 3'd7};
        send_pkt(p, 48'hFFFF_FFFF_FFFF);
        p = '{ftac_pkg::OP_SWEEP, 32'h0, 32'h0, 16'h0, 16'h0, 6'd0, 3'd0};
        send_pkt(p, clock_now + 48'd40);
        send_pkt(p, 48'd49000);
        send_pkt(p, 48'd60000);
        send_pkt(p, 48'hFFFF_FFFF_FFFF);
        clock_now = 48'd70000;

        write_threshold(32'd0);
        run_random(70, 1'b0);
        write_threshold(32'hFFFF_FFFF);
        run_random(70, 1'b1);
        write_threshold($urandom_range(1000, 200000));
        run_random(110, 1'b0);

        write_threshold(32'hFFFF_FFFF);
        fill_table(ftac_pkg::OP_INGRESS, 1030);
        idling_on = 1'b0;
        run_random(20, 1'b0);
        write_threshold(32'd0);
        p = '{ftac_pkg::OP_SWEEP, 32'h0, 32'h0, 16'h0, 16'h0, 6'd0, 3'd0};
        clock_now = clock_now + 48'd5;
        send_pkt(p, clock_now);
        run_random(10, 1'b0);
        drop_push();

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
